// ===== sv/kalman_angle_bias_filter_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the angle / bias filter checker
// Same-cycle and next-cycle implication forms on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_BIAS_FILTER_TOP_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define KABF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kabf assertion failed");

// consequent checked in the cycle after the antecedent
`define KABF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kabf assertion failed");

`endif

// ===== sv/kabf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_pkg
// Types and constants shared by the angle / bias filter modules.
// ----------------------------------------------------------------------------
package kabf_pkg;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int NOISE_WIDTH    = 31;

   localparam logic [1:0] CSR_IDX_ANGLE_NOISE   = 2'd0;
   localparam logic [1:0] CSR_IDX_BIAS_NOISE    = 2'd1;
   localparam logic [1:0] CSR_IDX_MEASURE_NOISE = 2'd2;

   localparam logic [NOISE_WIDTH-1:0] ANGLE_NOISE_RESET   = 31'd1073742;
   localparam logic [NOISE_WIDTH-1:0] BIAS_NOISE_RESET    = 31'd3221225;
   localparam logic [NOISE_WIDTH-1:0] MEASURE_NOISE_RESET = 31'd32212255;

   // quotient bits 32..0 of the gain division
   localparam logic [5:0] DIV_LAST_STEP = 6'd32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RT,
      ST_D,
      ST_P00,
      ST_P11,
      ST_DIV0,
      ST_DIV1,
      ST_Y,
      ST_ANG,
      ST_BIAS,
      ST_C10,
      ST_C11,
      ST_C01,
      ST_C00,
      ST_OUT
   } seq_state_type;

   typedef enum logic [1:0] {
      MP_IDLE,
      MP_LO,
      MP_HI,
      MP_FIN
   } mul_phase_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_FIN
   } div_phase_type;

   typedef struct packed {
      logic              start;
      logic              sh30;   // 1: shift product by 30, 0: by 16
      logic signed [32:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic signed [63:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic signed [31:0] num;
      logic        [32:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic signed [31:0] quo;
   } div_rsp_type;

endpackage

// ===== sv/kabf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_mul
// Shared multiplier: floor(a * b / 2^sh) saturated to 64 bits, 16 bits of
// |b| per cycle, low half then high half, then rounding and saturation.
// ----------------------------------------------------------------------------
module kabf_mul #(
   parameter int MAG_WIDTH = 36
) (
   input  logic                        clock,
   input  logic                        reset,
   input  kabf_pkg::mul_req_type       req,
   input  logic signed [MAG_WIDTH-1:0] op_a,
   output kabf_pkg::mul_rsp_type       rsp
);

   localparam int PW = MAG_WIDTH + 32;

   kabf_pkg::mul_phase_type phase_ff, phase_in;
   logic [MAG_WIDTH-1:0]    amag_ff, amag_in;
   logic [31:0]             bmag_ff, bmag_in;
   logic                    neg_ff, neg_in;
   logic                    sh30_ff, sh30_in;
   logic [PW-1:0]           acc_ff, acc_in;
   logic signed [63:0]      prod_ff, prod_in;
   logic                    done_ff, done_in;

   logic [15:0]             bsel;
   logic [MAG_WIDTH+15:0]   part;
   logic [PW-1:0]           quo;
   logic [PW-1:0]           qmag;
   logic                    rem_nz;
   logic                    pos_ovf;
   logic                    neg_ovf;

   assign bsel = (phase_ff == kabf_pkg::MP_LO) ? bmag_ff[15:0] : bmag_ff[31:16];
   assign part = (MAG_WIDTH + 16)'(amag_ff) * (MAG_WIDTH + 16)'(bsel);

   assign quo     = sh30_ff ? (acc_ff >> 30) : (acc_ff >> 16);
   assign rem_nz  = sh30_ff ? (acc_ff[29:0] != 30'd0) : (acc_ff[15:0] != 16'd0);
   assign qmag    = quo + PW'(neg_ff & rem_nz);
   assign pos_ovf = quo > PW'(64'h7FFF_FFFF_FFFF_FFFF);
   assign neg_ovf = qmag > PW'(64'h8000_0000_0000_0000);

   always_comb begin
      phase_in = phase_ff;
      amag_in  = amag_ff;
      bmag_in  = bmag_ff;
      neg_in   = neg_ff;
      sh30_in  = sh30_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         kabf_pkg::MP_IDLE: begin
            if (req.start) begin
               amag_in  = op_a[MAG_WIDTH-1] ? MAG_WIDTH'(-op_a) : MAG_WIDTH'(op_a);
               bmag_in  = req.b[32] ? 32'(-req.b) : req.b[31:0];
               neg_in   = op_a[MAG_WIDTH-1] ^ req.b[32];
               sh30_in  = req.sh30;
               phase_in = kabf_pkg::MP_LO;
            end
         end
         kabf_pkg::MP_LO: begin
            acc_in   = PW'(part);
            phase_in = kabf_pkg::MP_HI;
         end
         kabf_pkg::MP_HI: begin
            acc_in   = acc_ff + {part, 16'd0};
            phase_in = kabf_pkg::MP_FIN;
         end
         kabf_pkg::MP_FIN: begin
            if (neg_ff) begin
               prod_in = neg_ovf ? 64'sh8000_0000_0000_0000 : -$signed(qmag[63:0]);
            end else begin
               prod_in = pos_ovf ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(quo[63:0]);
            end
            done_in  = 1'b1;
            phase_in = kabf_pkg::MP_IDLE;
         end
         default: phase_in = kabf_pkg::MP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kabf_pkg::MP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      amag_ff <= amag_in;
      bmag_ff <= bmag_in;
      neg_ff  <= neg_in;
      sh30_ff <= sh30_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = prod_ff;

endmodule

// ===== sv/kabf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_div
// Gain divider: sat32(num * 2^30 / den), truncated toward zero, den > 0.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kabf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  kabf_pkg::div_req_type req,
   output kabf_pkg::div_rsp_type rsp
);

   kabf_pkg::div_phase_type phase_ff, phase_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [32:0]         rem_ff, rem_in;
   logic [32:0]         quo_ff, quo_in;
   logic [32:0]         den_ff, den_in;
   logic                neg_ff, neg_in;
   logic                ovf_ff, ovf_in;
   logic signed [31:0]  res_ff, res_in;
   logic                done_ff, done_in;

   logic [31:0]         mag;
   logic [33:0]         trial;
   logic                ge;

   assign mag   = req.num[31] ? 32'(-req.num) : req.num[31:0];
   assign trial = {rem_ff, quo_ff[32]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         kabf_pkg::DV_IDLE: begin
            if (req.start) begin
               // quotient >= 2^32 exactly when |num| >= 4 * den
               ovf_in   = {3'd0, mag} >= {req.den, 2'd0};
               rem_in   = {4'd0, mag[31:3]};
               quo_in   = {mag[2:0], 30'd0};
               den_in   = req.den;
               neg_in   = req.num[31];
               cnt_in   = kabf_pkg::DIV_LAST_STEP;
               phase_in = kabf_pkg::DV_RUN;
            end
         end
         kabf_pkg::DV_RUN: begin
            rem_in = ge ? 33'(trial - {1'b0, den_ff}) : trial[32:0];
            quo_in = {quo_ff[31:0], ge};
            if (cnt_ff == 6'd0) begin
               phase_in = kabf_pkg::DV_FIN;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         kabf_pkg::DV_FIN: begin
            if (neg_ff) begin
               res_in = (ovf_ff || quo_ff > 33'd2147483648) ? 32'sh8000_0000
                                                              : 32'(-$signed(quo_ff));
            end else begin
               res_in = (ovf_ff || quo_ff > 33'd2147483647) ? 32'sh7FFF_FFFF
                                                              : $signed(quo_ff[31:0]);
            end
            done_in  = 1'b1;
            phase_in = kabf_pkg::DV_IDLE;
         end
         default: phase_in = kabf_pkg::DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kabf_pkg::DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = res_ff;

endmodule

// ===== sv/kalman_angle_bias_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_top
// Two-state angle / gyro-bias Kalman filter, fixed point, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   req_* stream carries measured angle, gyro rate and step time in tdata and
//   the force flag in tuser. rsp_* stream returns filtered angle and bias.
//   Noise registers sit on the csr_* APB port at byte addresses 0, 4 and 8;
//   write them only while the filter is idle.
// Sequencing:
//   A filtering item makes ten passes through the shared multiplier and two
//   passes through the bit-serial gain divider before rsp_tvalid; with S not
//   positive the divider is skipped. A forced item goes straight to the
//   output register. req_tready is high only while the sequencer is idle,
//   one item at a time.
// Reset: synchronous; state and covariance clear to zero, noise registers
//   load their defaults.
// Stall: a finished result waits in the output register; the next item may
//   be accepted and run meanwhile, and it holds at the end until rsp drains.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: measured_angle[24:0], rate[52:25], step_time[68:53], zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // req_tuser: force_angle
   input  logic        req_tuser,
   // rsp_tdata: angle_out[31:0], bias_out[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [kabf_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int W  = VALUE_WIDTH;
   localparam int MW = (VALUE_WIDTH > 36) ? VALUE_WIDTH : 36;
   localparam int NW = kabf_pkg::NOISE_WIDTH;

   function automatic logic signed [W-1:0] sat_w(input logic signed [65:0] x);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = (66'sd1 <<< (W - 1)) - 66'sd1;
      lo = -hi - 66'sd1;
      if (x > hi) begin
         sat_w = hi[W-1:0];
      end else if (x < lo) begin
         sat_w = lo[W-1:0];
      end else begin
         sat_w = x[W-1:0];
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (x < -66'sd2147483648) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

   kabf_pkg::seq_state_type state_ff, state_in;
   logic                issued_ff, issued_in;
   logic signed [W-1:0] angle_ff, angle_in;
   logic signed [W-1:0] bias_ff, bias_in;
   logic signed [31:0]  cov00_ff, cov00_in;
   logic signed [31:0]  cov01_ff, cov01_in;
   logic signed [31:0]  cov10_ff, cov10_in;
   logic signed [31:0]  cov11_ff, cov11_in;
   logic signed [32:0]  d_ff, d_in;
   logic signed [31:0]  k0_ff, k0_in;
   logic signed [31:0]  k1_ff, k1_in;
   logic signed [W-1:0] y_ff, y_in;
   logic signed [24:0]  meas_ff, meas_in;
   logic signed [27:0]  rate_ff, rate_in;
   logic [15:0]         dt_ff, dt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_data_ff, rsp_data_in;
   logic [NW-1:0]       an_ff, an_in;
   logic [NW-1:0]       bn_ff, bn_in;
   logic [NW-1:0]       mn_ff, mn_in;

   kabf_pkg::mul_req_type mreq;
   kabf_pkg::mul_rsp_type mrsp;
   kabf_pkg::div_req_type dreq;
   kabf_pkg::div_rsp_type drsp;
   logic signed [MW-1:0]  mul_a;
   logic                  mul_go;
   logic                  div_go;

   logic signed [W-1:0]   rt;
   logic signed [35:0]    inner;
   logic signed [33:0]    s_sum;
   logic                  s_pos;
   logic signed [32:0]    dt_op;
   logic                  csr_we;
   logic [1:0]            csr_idx;

   assign rt    = sat_w(66'(rate_ff) - 66'(bias_ff));
   assign inner = 36'(d_ff) - 36'(cov01_ff) - 36'(cov10_ff) + $signed({5'd0, an_ff});
   assign s_sum = 34'(cov00_ff) + $signed({3'd0, mn_ff});
   assign s_pos = !s_sum[33] && (s_sum != 34'sd0);
   assign dt_op = $signed({17'd0, dt_ff});

   assign req_tready = (state_ff == kabf_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      an_in = an_ff;
      bn_in = bn_ff;
      mn_in = mn_ff;
      if (csr_we) begin
         unique case (csr_idx)
            kabf_pkg::CSR_IDX_ANGLE_NOISE:   an_in = csr_pwdata[NW-1:0];
            kabf_pkg::CSR_IDX_BIAS_NOISE:    bn_in = csr_pwdata[NW-1:0];
            kabf_pkg::CSR_IDX_MEASURE_NOISE: mn_in = csr_pwdata[NW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         kabf_pkg::CSR_IDX_ANGLE_NOISE:   csr_prdata = {1'b0, an_ff};
         kabf_pkg::CSR_IDX_BIAS_NOISE:    csr_prdata = {1'b0, bn_ff};
         kabf_pkg::CSR_IDX_MEASURE_NOISE: csr_prdata = {1'b0, mn_ff};
         default:                         csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      cov00_in     = cov00_ff;
      cov01_in     = cov01_ff;
      cov10_in     = cov10_ff;
      cov11_in     = cov11_ff;
      d_in         = d_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      y_in         = y_ff;
      meas_in      = meas_ff;
      rate_in      = rate_ff;
      dt_in        = dt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      mul_go       = 1'b0;
      div_go       = 1'b0;
      mul_a        = MW'(cov00_ff);
      mreq.sh30    = 1'b0;
      mreq.b       = dt_op;
      dreq.num     = cov00_ff;
      dreq.den     = s_sum[32:0];

      unique case (state_ff)
         kabf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               meas_in = $signed(req_tdata[24:0]);
               rate_in = $signed(req_tdata[52:25]);
               dt_in   = req_tdata[68:53];
               if (req_tuser) begin
                  angle_in = sat_w(66'($signed(req_tdata[24:0])));
                  state_in = kabf_pkg::ST_OUT;
               end else begin
                  state_in = kabf_pkg::ST_RT;
               end
            end
         end
         kabf_pkg::ST_RT: begin
            mul_go = 1'b1;
            mul_a  = MW'(rt);
            if (mrsp.done) begin
               angle_in = sat_w(66'(angle_ff) + 66'(mrsp.prod));
               state_in = kabf_pkg::ST_D;
            end
         end
         kabf_pkg::ST_D: begin
            mul_go = 1'b1;
            mul_a  = MW'(cov11_ff);
            if (mrsp.done) begin
               d_in     = mrsp.prod[32:0];
               state_in = kabf_pkg::ST_P00;
            end
         end
         kabf_pkg::ST_P00: begin
            // operand latched at issue, so off-diagonals update on completion
            mul_go = 1'b1;
            mul_a  = MW'(inner);
            if (mrsp.done) begin
               cov00_in = sat32(66'(cov00_ff) + 66'(mrsp.prod));
               cov01_in = sat32(66'(cov01_ff) - 66'(d_ff));
               cov10_in = sat32(66'(cov10_ff) - 66'(d_ff));
               state_in = kabf_pkg::ST_P11;
            end
         end
         kabf_pkg::ST_P11: begin
            mul_go = 1'b1;
            mul_a  = MW'($signed({1'b0, bn_ff}));
            if (mrsp.done) begin
               cov11_in = sat32(66'(cov11_ff) + 66'(mrsp.prod));
               state_in = kabf_pkg::ST_DIV0;
            end
         end
         kabf_pkg::ST_DIV0: begin
            if (!s_pos) begin
               k0_in    = 32'sd0;
               k1_in    = 32'sd0;
               state_in = kabf_pkg::ST_Y;
            end else begin
               div_go = 1'b1;
               if (drsp.done) begin
                  k0_in    = drsp.quo;
                  state_in = kabf_pkg::ST_DIV1;
               end
            end
         end
         kabf_pkg::ST_DIV1: begin
            div_go   = 1'b1;
            dreq.num = cov10_ff;
            if (drsp.done) begin
               k1_in    = drsp.quo;
               state_in = kabf_pkg::ST_Y;
            end
         end
         kabf_pkg::ST_Y: begin
            y_in     = sat_w(66'(meas_ff) - 66'(angle_ff));
            state_in = kabf_pkg::ST_ANG;
         end
         kabf_pkg::ST_ANG: begin
            mul_go    = 1'b1;
            mul_a     = MW'(y_ff);
            mreq.b    = 33'(k0_ff);
            mreq.sh30 = 1'b1;
            if (mrsp.done) begin
               angle_in = sat_w(66'(angle_ff) + 66'(mrsp.prod));
               state_in = kabf_pkg::ST_BIAS;
            end
         end
         kabf_pkg::ST_BIAS: begin
            mul_go    = 1'b1;
            mul_a     = MW'(y_ff);
            mreq.b    = 33'(k1_ff);
            mreq.sh30 = 1'b1;
            if (mrsp.done) begin
               bias_in  = sat_w(66'(bias_ff) + 66'(mrsp.prod));
               state_in = kabf_pkg::ST_C10;
            end
         end
         // covariance shrink: each row is read before it is overwritten
         kabf_pkg::ST_C10: begin
            mul_go    = 1'b1;
            mul_a     = MW'(cov00_ff);
            mreq.b    = 33'(k1_ff);
            mreq.sh30 = 1'b1;
            if (mrsp.done) begin
               cov10_in = sat32(66'(cov10_ff) - 66'(mrsp.prod));
               state_in = kabf_pkg::ST_C11;
            end
         end
         kabf_pkg::ST_C11: begin
            mul_go    = 1'b1;
            mul_a     = MW'(cov01_ff);
            mreq.b    = 33'(k1_ff);
            mreq.sh30 = 1'b1;
            if (mrsp.done) begin
               cov11_in = sat32(66'(cov11_ff) - 66'(mrsp.prod));
               state_in = kabf_pkg::ST_C01;
            end
         end
         kabf_pkg::ST_C01: begin
            mul_go    = 1'b1;
            mul_a     = MW'(cov01_ff);
            mreq.b    = 33'(k0_ff);
            mreq.sh30 = 1'b1;
            if (mrsp.done) begin
               cov01_in = sat32(66'(cov01_ff) - 66'(mrsp.prod));
               state_in = kabf_pkg::ST_C00;
            end
         end
         kabf_pkg::ST_C00: begin
            mul_go    = 1'b1;
            mul_a     = MW'(cov00_ff);
            mreq.b    = 33'(k0_ff);
            mreq.sh30 = 1'b1;
            if (mrsp.done) begin
               cov00_in = sat32(66'(cov00_ff) - 66'(mrsp.prod));
               state_in = kabf_pkg::ST_OUT;
            end
         end
         kabf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sat32(66'(bias_ff)), sat32(66'(angle_ff))};
               state_in     = kabf_pkg::ST_IDLE;
            end
         end
         default: state_in = kabf_pkg::ST_IDLE;
      endcase

      mreq.start = mul_go & ~issued_ff;
      dreq.start = div_go & ~issued_ff;
      issued_in  = (mul_go | div_go) & ~(mrsp.done | drsp.done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kabf_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         bias_ff      <= '0;
         cov00_ff     <= '0;
         cov01_ff     <= '0;
         cov10_ff     <= '0;
         cov11_ff     <= '0;
         an_ff        <= kabf_pkg::ANGLE_NOISE_RESET;
         bn_ff        <= kabf_pkg::BIAS_NOISE_RESET;
         mn_ff        <= kabf_pkg::MEASURE_NOISE_RESET;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         cov00_ff     <= cov00_in;
         cov01_ff     <= cov01_in;
         cov10_ff     <= cov10_in;
         cov11_ff     <= cov11_in;
         an_ff        <= an_in;
         bn_ff        <= bn_in;
         mn_ff        <= mn_in;
      end
      d_ff        <= d_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      y_ff        <= y_in;
      meas_ff     <= meas_in;
      rate_ff     <= rate_in;
      dt_ff       <= dt_in;
      rsp_data_ff <= rsp_data_in;
   end

   kabf_mul #(
      .MAG_WIDTH(MW)
   ) u_mul (
      .clock(clock),
      .reset(reset),
      .req  (mreq),
      .op_a (mul_a),
      .rsp  (mrsp)
   );

   kabf_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (dreq),
      .rsp  (drsp)
   );

endmodule

// ===== sv/kabf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_checker
// Port-level assertions for the angle / bias filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "kalman_angle_bias_filter_top_assert.svh"

module kabf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [kabf_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   logic wr_angle_noise;

   assign wr_angle_noise = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                           (csr_paddr[3:2] == kabf_pkg::CSR_IDX_ANGLE_NOISE);

   // one item at a time: the sequencer leaves idle after every transfer
   `KABF_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)

   // a new result is loaded only as the sequencer returns to idle
   `KABF_ASSERT_NOW(a_rsp_rise_idle, $rose(rsp_tvalid), req_tready)

   `KABF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))

   // register readback shows the low 31 bits of the last write
   `KABF_ASSERT_NEXT(a_csr_readback, wr_angle_noise,
                     csr_paddr[3:2] != kabf_pkg::CSR_IDX_ANGLE_NOISE ||
                     csr_prdata == {1'b0, $past(csr_pwdata[30:0])})

endmodule

bind kalman_angle_bias_filter_top kabf_checker u_kabf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_psel   (csr_psel),
   .csr_penable(csr_penable),
   .csr_pwrite (csr_pwrite),
   .csr_paddr  (csr_paddr),
   .csr_pwdata (csr_pwdata),
   .csr_prdata (csr_prdata),
   .csr_pready (csr_pready)
);
